// ===== hdl/dvv_pkg.sv =====
// dvv_pkg: shared types, codes and fixed-point helpers for the rigid dipole
// velocity-Verlet step block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dvv_pkg;

    localparam int DEF_MAX_PARTICLES = 4096;
    localparam int DEF_NUM_TYPES     = 16;

    localparam int SQ_STEPS   = 32;
    localparam int DV_STEPS   = 32;
    localparam int PEND_BKT_W = 5;
    localparam int PEND_BKTS  = 1 << PEND_BKT_W;
    localparam int PEND_W     = 8;
    localparam int FIFO_AW    = 7;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int CREDIT_W   = FIFO_AW + 1;

    localparam logic [31:0] FRAC_0P4 = 32'd26214;
    localparam logic [31:0] Q_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN    = 32'h8000_0000;

    typedef enum logic [2:0] {
        ACT_LOAD_POS    = 3'd0,
        ACT_LOAD_VEL    = 3'd1,
        ACT_LOAD_DIPOLE = 3'd2,
        ACT_LOAD_ANGVEL = 3'd3,
        ACT_LOAD_TYPE   = 3'd4,
        ACT_INIT_HALF   = 3'd5,
        ACT_FINAL_HALF  = 3'd6,
        ACT_READ        = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        KIND_POS    = 2'd0,
        KIND_VEL    = 2'd1,
        KIND_DIPOLE = 2'd2,
        KIND_ANGVEL = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_HALF_FORCE_STEP = 1'b0,
        CFG_POSITION_STEP   = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic        valid;
        logic        ld;
        logic        ty;
        logic        rd;
        logic        st;
        logic        init;
        logic        dip;
        logic [1:0]  sel;
        logic [11:0] idx;
        logic [7:0]  typ;
    } t_ctl;

    typedef struct packed {
        t_ctl             c;
        logic [2:0][31:0] f;
        logic [2:0][31:0] t;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] mu;
        logic [2:0][31:0] om;
        logic [2:0][31:0] kf;
        logic [2:0][31:0] kt;
        logic [2:0][31:0] pd;
        logic [2:0][31:0] cr;
        logic [2:0][31:0] g;
        logic [31:0]      invm;
        logic [31:0]      invi;
        logic [31:0]      len;
        logic [31:0]      kv;
        logic [31:0]      kw;
        logic [31:0]      qd2;
        logic [31:0]      md2;
        logic [31:0]      inr;
        logic [5:0][63:0] cp;
        logic [2:0][63:0] sq;
        logic [2:0][63:0] p;
        logic [63:0]      sv;
        logic [63:0]      sres;
        logic [2:0][62:0] pm;
        logic [2:0][31:0] dd;
        logic [2:0][31:0] dq;
        logic [2:0][31:0] dlo;
        logic [2:0][32:0] drem;
        logic [2:0]       dovf;
        logic [2:0]       dneg;
    } t_pipe;

    typedef struct packed {
        logic [11:0]      idx;
        logic [3:0]       mask;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] mu;
        logic [2:0][31:0] om;
    } t_entry;

    function automatic logic [31:0] sat_q(input logic [65:0] v);
        if (v[65:31] == {35{1'b0}} || v[65:31] == {35{1'b1}}) begin
            return v[31:0];
        end
        return v[65] ? Q_MIN : Q_MAX;
    endfunction

    // floor shift of a signed 64-bit product, then saturate
    function automatic logic [31:0] sat_shr(input logic [63:0] p, input int unsigned sh);
        logic [65:0] e;
        e = {{2{p[63]}}, p};
        e = 66'($signed(e) >>> sh);
        return sat_q(e);
    endfunction

    function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return sat_shr(64'(p), 16);
    endfunction

    function automatic logic [31:0] qadd(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat_q({{33{s[32]}}, s});
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? 32'(~x + 32'd1) : x;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dipole_velocity_verlet_step.sv =====
// dipole_velocity_verlet_step: top level of the rigid dipole velocity-Verlet step.
// Depends on dvv_pkg for codes, pipeline structs and fixed-point helpers.
//
// Usage: items enter on the i_in_* channel (valid/ready), results leave on the
// o_out_* channel (valid/ready), registers are written on the i_cfg_* channel,
// which is always ready. Loads (actions 0-4) emit nothing; read emits four
// results; step actions emit the vectors they update, last set on the final one.
// An item's results leave one per cycle while the receiver is ready. Throughput:
// one item per cycle unless an input wait below holds it, set by the slot memories'
// single read and write port, limited by the output at one result per cycle.
// An item that reads a slot waits while a write to a slot of the same hash
// bucket is still in the pipeline; a step waits while a type load is in flight.
// The pipeline never stalls: each item that emits results reserves one entry of
// a 128-entry result queue at acceptance, so a stalled receiver only holds back
// new reads and steps once the queue is fully reserved. Reset clears the pipeline
// valid bits, queue pointers, hazard counters and both registers, fills the credit.
// Slot and type stores are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module dipole_velocity_verlet_step #(
    parameter int MAX_PARTICLES = dvv_pkg::DEF_MAX_PARTICLES,
    parameter int NUM_TYPES     = dvv_pkg::DEF_NUM_TYPES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_action,
    input  wire logic [11:0] i_particle_index,
    input  wire logic [3:0]  i_particle_type,
    input  wire logic        i_in_group,
    input  wire logic [31:0] i_vec_x,
    input  wire logic [31:0] i_vec_y,
    input  wire logic [31:0] i_vec_z,
    input  wire logic [31:0] i_aux_x,
    input  wire logic [31:0] i_aux_y,
    input  wire logic [31:0] i_aux_z,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [11:0]      o_out_index,
    output logic [1:0]       o_vector_kind,
    output logic [31:0]      o_comp_x,
    output logic [31:0]      o_comp_y,
    output logic [31:0]      o_comp_z,
    output logic             o_last
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int SQ = dvv_pkg::SQ_STEPS;
    localparam int DV = dvv_pkg::DV_STEPS;
    localparam int PB = dvv_pkg::PEND_BKT_W;
    localparam int PW = dvv_pkg::PEND_W;
    localparam int FA = dvv_pkg::FIFO_AW;
    localparam int CW = dvv_pkg::CREDIT_W;

    // configuration
    logic [30:0] r_hfs;
    logic [30:0] r_ps;
    logic [31:0] hfs;
    logic [31:0] ps;

    assign o_cfg_ready = 1'b1;
    assign hfs = {1'b0, r_hfs};
    assign ps  = {1'b0, r_ps};

    // stores
    logic [95:0] r_mem_pos [MAX_PARTICLES];
    logic [95:0] r_mem_vel [MAX_PARTICLES];
    logic [95:0] r_mem_mu  [MAX_PARTICLES];
    logic [95:0] r_mem_om  [MAX_PARTICLES];
    logic [95:0] r_rd_pos;
    logic [95:0] r_rd_vel;
    logic [95:0] r_rd_mu;
    logic [95:0] r_rd_om;
    logic [31:0] r_tab_invm [NUM_TYPES];
    logic [31:0] r_tab_invi [NUM_TYPES];
    logic [31:0] r_tab_len  [NUM_TYPES];

    // pipeline
    dvv_pkg::t_pipe r_p0, r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7, r_p8;
    dvv_pkg::t_pipe n_p0, n_p1, n_p2, n_p3, n_p4, n_p5, n_p6, n_p7, n_p8;
    dvv_pkg::t_pipe r_sq [SQ+1];
    dvv_pkg::t_pipe n_sq [SQ+1];
    dvv_pkg::t_pipe r_dv [DV+1];
    dvv_pkg::t_pipe n_dv [DV+1];
    dvv_pkg::t_pipe wb;

    // hazards and credits
    logic [PW-1:0] r_pend [dvv_pkg::PEND_BKTS];
    logic [PW-1:0] n_pend [dvv_pkg::PEND_BKTS];
    logic [PW-1:0] r_ty_pend;
    logic [CW-1:0] r_credit;

    // result queue
    dvv_pkg::t_entry r_fifo [dvv_pkg::FIFO_DEPTH];
    dvv_pkg::t_entry r_head;
    dvv_pkg::t_entry entry;
    logic [FA-1:0] r_wp;
    logic [FA-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          r_hv;
    logic [3:0]    r_mask;

    // input decode
    logic [15:0]   idx16;
    logic [7:0]    typ8;
    logic [AW-1:0] in_addr;
    logic [TW-1:0] in_taddr;
    logic          idx_ok, typ_ok;
    logic          d_ld, d_ty, d_rd, d_st, d_dip;
    logic          writer, reader, produces, hazard, accept;
    logic [PB-1:0] in_bkt;

    assign idx16    = {4'd0, i_particle_index};
    assign typ8     = {4'd0, i_particle_type};
    assign in_addr  = idx16[AW-1:0];
    assign in_taddr = typ8[TW-1:0];
    assign in_bkt   = i_particle_index[PB-1:0];
    assign idx_ok   = {5'd0, i_particle_index} < 17'(MAX_PARTICLES);
    assign typ_ok   = {5'd0, i_particle_type} < 9'(NUM_TYPES);

    assign d_ld  = (i_action == dvv_pkg::ACT_LOAD_POS || i_action == dvv_pkg::ACT_LOAD_VEL
                 || i_action == dvv_pkg::ACT_LOAD_DIPOLE || i_action == dvv_pkg::ACT_LOAD_ANGVEL)
                 && idx_ok;
    assign d_ty  = (i_action == dvv_pkg::ACT_LOAD_TYPE) && typ_ok;
    assign d_rd  = (i_action == dvv_pkg::ACT_READ) && idx_ok;
    assign d_st  = (i_action == dvv_pkg::ACT_INIT_HALF || i_action == dvv_pkg::ACT_FINAL_HALF)
                 && idx_ok && typ_ok && i_in_group;
    assign d_dip = d_st && ($signed(r_tab_len[in_taddr]) > 0);

    assign writer   = d_ld || d_st;
    assign reader   = d_st || d_rd;
    assign produces = d_st || d_rd;
    assign hazard   = (reader && r_pend[in_bkt] != '0)
                   || (d_st && r_ty_pend != '0)
                   || (produces && r_credit == '0);
    assign o_in_ready = !hazard;
    assign accept     = i_in_valid && !hazard;

    // stage 0: capture item and type constants
    always_comb begin
        n_p0 = r_p0;
        n_p0.c.valid = accept && (d_ld || d_ty || d_rd || d_st);
        n_p0.c.ld    = d_ld;
        n_p0.c.ty    = d_ty;
        n_p0.c.rd    = d_rd;
        n_p0.c.st    = d_st;
        n_p0.c.init  = (i_action == dvv_pkg::ACT_INIT_HALF);
        n_p0.c.dip   = d_dip;
        n_p0.c.sel   = i_action[1:0];
        n_p0.c.idx   = i_particle_index;
        n_p0.c.typ   = typ8;
        n_p0.f       = {i_vec_z, i_vec_y, i_vec_x};
        n_p0.t       = {i_aux_z, i_aux_y, i_aux_x};
        n_p0.invm    = r_tab_invm[in_taddr];
        n_p0.invi    = r_tab_invi[in_taddr];
        n_p0.len     = r_tab_len[in_taddr];
    end

    // stage 1: memory data, kick factors, quarter diameter squared
    always_comb begin
        logic signed [63:0] dsq;
        n_p1     = r_p0;
        n_p1.pos = r_rd_pos;
        n_p1.vel = r_rd_vel;
        n_p1.mu  = r_rd_mu;
        n_p1.om  = r_rd_om;
        n_p1.kv  = dvv_pkg::qmul(hfs, r_p0.invm);
        n_p1.kw  = dvv_pkg::qmul(hfs, r_p0.invi);
        dsq      = $signed(r_p0.f[2]) * $signed(r_p0.f[2]);
        n_p1.qd2 = dvv_pkg::sat_shr(64'(dsq), 18);
    end

    // stage 2: force and torque kicks, mass times quarter d^2
    always_comb begin
        n_p2 = r_p1;
        for (int i = 0; i < 3; i++) begin
            n_p2.kf[i] = dvv_pkg::qmul(r_p1.kv, r_p1.f[i]);
            n_p2.kt[i] = dvv_pkg::qmul(r_p1.kw, r_p1.t[i]);
        end
        n_p2.md2 = dvv_pkg::qmul(r_p1.f[0], r_p1.qd2);
    end

    // stage 3: velocity and omega update, inertia
    always_comb begin
        logic signed [63:0] ip;
        n_p3 = r_p2;
        if (r_p2.c.ld) begin
            n_p3.pos = r_p2.f;
            n_p3.vel = r_p2.f;
            n_p3.mu  = r_p2.f;
            n_p3.om  = r_p2.f;
        end else if (r_p2.c.st) begin
            for (int i = 0; i < 3; i++) begin
                n_p3.vel[i] = dvv_pkg::qadd(r_p2.vel[i], r_p2.kf[i]);
                if (r_p2.c.dip) begin
                    n_p3.om[i] = dvv_pkg::qadd(r_p2.om[i], r_p2.kt[i]);
                end
            end
        end
        ip       = $signed(r_p2.md2) * $signed(dvv_pkg::FRAC_0P4);
        n_p3.inr = dvv_pkg::sat_shr(64'(ip), 16);
    end

    // stage 4: drift products, cross products
    always_comb begin
        logic signed [63:0] c [6];
        n_p4 = r_p3;
        for (int i = 0; i < 3; i++) begin
            n_p4.pd[i] = dvv_pkg::qmul(ps, r_p3.vel[i]);
        end
        c[0] = $signed(r_p3.om[1]) * $signed(r_p3.mu[2]);
        c[1] = $signed(r_p3.om[2]) * $signed(r_p3.mu[1]);
        c[2] = $signed(r_p3.om[2]) * $signed(r_p3.mu[0]);
        c[3] = $signed(r_p3.om[0]) * $signed(r_p3.mu[2]);
        c[4] = $signed(r_p3.om[0]) * $signed(r_p3.mu[1]);
        c[5] = $signed(r_p3.om[1]) * $signed(r_p3.mu[0]);
        for (int j = 0; j < 6; j++) begin
            n_p4.cp[j] = 64'(c[j]);
        end
    end

    // stage 5: position drift, cross terms
    always_comb begin
        logic [64:0] df;
        logic [65:0] e;
        n_p5 = r_p4;
        df   = '0;
        e    = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_p4.c.st && r_p4.c.init) begin
                n_p5.pos[i] = dvv_pkg::qadd(r_p4.pos[i], r_p4.pd[i]);
            end
            df = {r_p4.cp[2*i][63], r_p4.cp[2*i]} - {r_p4.cp[2*i+1][63], r_p4.cp[2*i+1]};
            e  = 66'($signed({df[64], df}) >>> 16);
            n_p5.cr[i] = dvv_pkg::sat_q(e);
        end
    end

    // stage 6: rotation increment
    always_comb begin
        n_p6 = r_p5;
        for (int i = 0; i < 3; i++) begin
            n_p6.g[i] = dvv_pkg::qmul(ps, r_p5.cr[i]);
        end
    end

    // stage 7: rotated dipole before renormalization
    always_comb begin
        n_p7 = r_p6;
        for (int i = 0; i < 3; i++) begin
            n_p7.g[i] = dvv_pkg::qadd(r_p6.mu[i], r_p6.g[i]);
        end
    end

    // stage 8: squares and length products
    always_comb begin
        logic signed [63:0] s;
        logic signed [63:0] q;
        n_p8 = r_p7;
        for (int i = 0; i < 3; i++) begin
            s = $signed(r_p7.g[i]) * $signed(r_p7.g[i]);
            q = $signed(r_p7.g[i]) * $signed(r_p7.len);
            n_p8.sq[i] = 64'(s);
            n_p8.p[i]  = 64'(q);
        end
    end

    // stage 9 (sqrt input), sqrt iterations, divider init and iterations
    always_comb begin
        dvv_pkg::t_pipe w;
        logic [63:0] a;
        logic [63:0] bitv;
        logic [32:0] rs;
        w = r_p8;
        w.sv   = r_p8.sq[0] + r_p8.sq[1] + r_p8.sq[2];
        w.sres = '0;
        for (int i = 0; i < 3; i++) begin
            a = r_p8.p[i][63] ? 64'(~r_p8.p[i] + 64'd1) : r_p8.p[i];
            w.pm[i]   = a[62:0];
            w.dneg[i] = r_p8.p[i][63];
        end
        if (r_p8.c.ty) begin
            w.pm[0]   = 63'(64'd1 << 32);
            w.pm[1]   = 63'(64'd1 << 32);
            w.dd[0]   = dvv_pkg::abs32(r_p8.f[0]);
            w.dd[1]   = dvv_pkg::abs32(r_p8.inr);
            w.dneg[0] = r_p8.f[0][31];
            w.dneg[1] = r_p8.inr[31];
        end
        n_sq[0] = w;

        for (int k = 0; k < SQ; k++) begin
            w    = r_sq[k];
            bitv = 64'd1 << (62 - 2 * k);
            a    = w.sres + bitv;
            if (w.sv >= a) begin
                w.sv   = w.sv - a;
                w.sres = (w.sres >> 1) + bitv;
            end else begin
                w.sres = w.sres >> 1;
            end
            n_sq[k+1] = w;
        end

        w = r_sq[SQ];
        for (int i = 0; i < 3; i++) begin
            if (w.c.st) begin
                w.dd[i] = w.sres[31:0];
            end
            w.dovf[i] = {1'b0, w.pm[i][62:32]} >= w.dd[i];
            w.drem[i] = {2'b0, w.pm[i][62:32]};
            w.dlo[i]  = w.pm[i][31:0];
            w.dq[i]   = '0;
        end
        n_dv[0] = w;

        for (int k = 0; k < DV; k++) begin
            w = r_dv[k];
            for (int i = 0; i < 3; i++) begin
                rs = {w.drem[i][31:0], w.dlo[i][31]};
                w.dlo[i] = {w.dlo[i][30:0], 1'b0};
                if (rs >= {1'b0, w.dd[i]}) begin
                    w.drem[i] = rs - {1'b0, w.dd[i]};
                    w.dq[i]   = {w.dq[i][30:0], 1'b1};
                end else begin
                    w.drem[i] = rs;
                    w.dq[i]   = {w.dq[i][30:0], 1'b0};
                end
            end
            n_dv[k+1] = w;
        end
    end

    // writeback
    logic [2:0][31:0] q_step;
    logic [2:0][31:0] q_recip;
    logic [2:0][31:0] mu_new;
    logic [AW-1:0]    wb_addr;
    logic [TW-1:0]    wb_taddr;
    logic [15:0]      wb_idx16;
    logic             wb_writer, wb_push, wb_rot;
    logic             we_pos, we_vel, we_mu, we_om;
    logic [PB-1:0]    wb_bkt;

    assign wb       = r_dv[DV];
    assign wb_idx16 = {4'd0, wb.c.idx};
    assign wb_addr  = wb_idx16[AW-1:0];
    assign wb_taddr = wb.c.typ[TW-1:0];
    assign wb_bkt   = wb.c.idx[PB-1:0];
    assign wb_writer = wb.c.valid && (wb.c.ld || wb.c.st);
    assign wb_push   = wb.c.valid && (wb.c.rd || wb.c.st);
    assign wb_rot    = wb.c.st && wb.c.init && wb.c.dip && (wb.dd[0] != '0);

    always_comb begin
        logic [31:0] m;
        for (int i = 0; i < 3; i++) begin
            if (wb.dneg[i]) begin
                q_step[i] = (wb.dovf[i] || wb.dq[i] > 32'h8000_0000)
                          ? dvv_pkg::Q_MIN : 32'(~wb.dq[i] + 32'd1);
            end else begin
                q_step[i] = (wb.dovf[i] || wb.dq[i][31]) ? dvv_pkg::Q_MAX : wb.dq[i];
            end
            m = (wb.dovf[i] || wb.dq[i][31]) ? dvv_pkg::Q_MAX : wb.dq[i];
            q_recip[i] = wb.dneg[i] ? 32'(~m + 32'd1) : m;
            mu_new[i]  = wb_rot ? q_step[i] : wb.mu[i];
        end
    end

    assign we_pos = wb.c.valid && ((wb.c.ld && wb.c.sel == dvv_pkg::KIND_POS)
                                || (wb.c.st && wb.c.init));
    assign we_vel = wb.c.valid && ((wb.c.ld && wb.c.sel == dvv_pkg::KIND_VEL) || wb.c.st);
    assign we_mu  = wb.c.valid && ((wb.c.ld && wb.c.sel == dvv_pkg::KIND_DIPOLE) || wb_rot);
    assign we_om  = wb.c.valid && ((wb.c.ld && wb.c.sel == dvv_pkg::KIND_ANGVEL)
                                || (wb.c.st && wb.c.dip));

    always_comb begin
        entry.idx = wb.c.idx;
        entry.pos = wb.pos;
        entry.vel = wb.vel;
        entry.mu  = mu_new;
        entry.om  = wb.om;
        if (wb.c.rd) begin
            entry.mask = 4'b1111;
        end else if (wb.c.init) begin
            entry.mask = {wb.c.dip, wb.c.dip, 2'b11};
        end else begin
            entry.mask = {wb.c.dip, 3'b010};
        end
    end

    // memories and tables
    always_ff @(posedge i_clk) begin
        r_rd_pos <= r_mem_pos[in_addr];
        r_rd_vel <= r_mem_vel[in_addr];
        r_rd_mu  <= r_mem_mu[in_addr];
        r_rd_om  <= r_mem_om[in_addr];
        if (we_pos) begin
            r_mem_pos[wb_addr] <= wb.pos;
        end
        if (we_vel) begin
            r_mem_vel[wb_addr] <= wb.vel;
        end
        if (we_mu) begin
            r_mem_mu[wb_addr] <= mu_new;
        end
        if (we_om) begin
            r_mem_om[wb_addr] <= wb.om;
        end
        if (wb.c.valid && wb.c.ty) begin
            r_tab_invm[wb_taddr] <= q_recip[0];
            r_tab_invi[wb_taddr] <= q_recip[1];
            r_tab_len[wb_taddr]  <= wb.f[1];
        end
        if (wb_push) begin
            r_fifo[r_wp] <= entry;
        end
    end

    // output serializer
    dvv_pkg::t_kind kind;
    logic [3:0]     kbit;
    logic           out_fire, pop, head_load;

    always_comb begin
        if (r_mask[0]) begin
            kind = dvv_pkg::KIND_POS;
        end else if (r_mask[1]) begin
            kind = dvv_pkg::KIND_VEL;
        end else if (r_mask[2]) begin
            kind = dvv_pkg::KIND_DIPOLE;
        end else begin
            kind = dvv_pkg::KIND_ANGVEL;
        end
        kbit = 4'd1 << kind;
        case (kind)
            dvv_pkg::KIND_POS:    {o_comp_z, o_comp_y, o_comp_x} = r_head.pos;
            dvv_pkg::KIND_VEL:    {o_comp_z, o_comp_y, o_comp_x} = r_head.vel;
            dvv_pkg::KIND_DIPOLE: {o_comp_z, o_comp_y, o_comp_x} = r_head.mu;
            default:              {o_comp_z, o_comp_y, o_comp_x} = r_head.om;
        endcase
    end

    assign o_out_valid   = r_hv;
    assign o_out_index   = r_head.idx;
    assign o_vector_kind = kind;
    assign o_last        = (r_mask & ~kbit) == 4'd0;
    assign out_fire      = r_hv && i_out_ready;
    assign pop           = out_fire && o_last;
    assign head_load     = (!r_hv || pop) && r_cnt != '0;

    // bucket counters of writes in flight
    always_comb begin
        for (int b = 0; b < dvv_pkg::PEND_BKTS; b++) begin
            n_pend[b] = r_pend[b]
                      + PW'(accept && writer && in_bkt == PB'(b))
                      - PW'(wb_writer && wb_bkt == PB'(b));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hfs     <= '0;
            r_ps      <= '0;
            r_p0.c.valid <= 1'b0;
            r_p1.c.valid <= 1'b0;
            r_p2.c.valid <= 1'b0;
            r_p3.c.valid <= 1'b0;
            r_p4.c.valid <= 1'b0;
            r_p5.c.valid <= 1'b0;
            r_p6.c.valid <= 1'b0;
            r_p7.c.valid <= 1'b0;
            r_p8.c.valid <= 1'b0;
            for (int k = 0; k <= SQ; k++) begin
                r_sq[k].c.valid <= 1'b0;
            end
            for (int k = 0; k <= DV; k++) begin
                r_dv[k].c.valid <= 1'b0;
            end
            for (int b = 0; b < dvv_pkg::PEND_BKTS; b++) begin
                r_pend[b] <= '0;
            end
            r_ty_pend <= '0;
            r_credit  <= CW'(dvv_pkg::FIFO_DEPTH);
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
            r_hv      <= 1'b0;
            r_mask    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    dvv_pkg::CFG_HALF_FORCE_STEP: r_hfs <= i_cfg_data[30:0];
                    dvv_pkg::CFG_POSITION_STEP:   r_ps  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
            r_p4 <= n_p4;
            r_p5 <= n_p5;
            r_p6 <= n_p6;
            r_p7 <= n_p7;
            r_p8 <= n_p8;
            r_sq <= n_sq;
            r_dv <= n_dv;
            r_pend <= n_pend;
            r_ty_pend <= r_ty_pend + PW'(accept && d_ty) - PW'(wb.c.valid && wb.c.ty);
            r_credit  <= r_credit - CW'(accept && produces) + CW'(pop);
            if (wb_push) begin
                r_wp <= r_wp + FA'(1);
            end
            r_cnt <= r_cnt + CW'(wb_push) - CW'(head_load);
            if (head_load) begin
                r_rp   <= r_rp + FA'(1);
                r_head <= r_fifo[r_rp];
                r_mask <= r_fifo[r_rp].mask;
                r_hv   <= 1'b1;
            end else if (out_fire) begin
                if (o_last) begin
                    r_hv <= 1'b0;
                end
                r_mask <= r_mask & ~kbit;
            end
        end
    end

endmodule

`default_nettype wire
